### hdl/kcpt_pkg.sv
// shared constants, types and helper functions for the closest prior time selector
package kcpt_pkg;

  localparam int MAX_PICK   = 16;
  localparam int INDEX_BITS = 16;

  localparam int TIME_W    = 32;
  localparam int GAP_W     = TIME_W + 1;
  localparam int PICK_W    = 5;
  localparam int EMPTY_W   = 5;
  localparam int SEEN_W    = 17;
  localparam int SLOT_BITS = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int CNT_W     = $clog2(MAX_PICK + 1);
  localparam int ENTRY_W   = INDEX_BITS + TIME_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = TIME_W;

  localparam logic [SEEN_W-1:0]  SEEN_MAX  = {SEEN_W{1'b1}};
  localparam logic [EMPTY_W-1:0] EMPTY_MAX = {EMPTY_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT  = 1'b1;

  typedef logic signed [GAP_W-1:0] gap_t;

  function automatic gap_t gap_of(input logic [TIME_W-1:0] target,
                                  input logic [TIME_W-1:0] t);
    gap_t a;
    gap_t b;
    a = $signed({target[TIME_W-1], target});
    b = $signed({t[TIME_W-1], t});
    return a - b;
  endfunction

  function automatic logic gap_pos(input gap_t g);
    return !g[GAP_W-1] && (g != '0);
  endfunction

endpackage

### hdl/kcpt_ram.sv
// generic single write port ram with registered read
module kcpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/k_closest_prior_time_select.sv
// top level of the closest prior time selector: control, slot store and result output
//
// A record is taken while busy_o is low. When it displaces the tracked largest-gap
// slot, a rescan follows that reads slots 0 to pick_count-1 through the slot
// memory's single read port, one slot a cycle; it ends early once an empty slot
// is tracked. A record marked last is followed by its results, one per cycle
// straight from the slot memory: pick_count results, or a single failure result.
// Results carry a one-cycle strobe and cannot be held off.
// busy_o is high while a rescan or readout runs; configuration may be written
// only while busy_o is low and no transaction is pending.
module k_closest_prior_time_select
  import kcpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [TIME_W-1:0]     item_time_i,
  input  logic [INDEX_BITS-1:0] item_index_i,
  input  logic                  is_last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output logic                  result_strobe_o,
  output logic                  found_o,
  output logic [SLOT_BITS-1:0]  slot_number_o,
  output logic [INDEX_BITS-1:0] chosen_index_o,
  output logic [TIME_W-1:0]     chosen_time_o,
  output logic                  last_result_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [TIME_W-1:0]    target_q;
  logic [PICK_W-1:0]    pick_q;
  gap_t                 largest_q, largest_d;
  logic [SLOT_BITS-1:0] lslot_q, lslot_d;
  logic [EMPTY_W-1:0]   empty_q, empty_d;
  logic [SEEN_W-1:0]    seen_q, seen_d;
  logic                 last_q, last_d;
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic                 rvld_q, rvld_d;
  logic [SLOT_BITS-1:0] rslot_q, rslot_d;
  logic                 strobe_q, strobe_d;
  logic                 found_q, found_d;
  logic [SLOT_BITS-1:0] oslot_q, oslot_d;
  logic                 olast_q, olast_d;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  logic [SLOT_BITS-1:0] ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                 accept;
  logic                 n_ok;
  logic [CNT_W-1:0]     n_cnt;
  logic                 fill;
  logic                 repl;
  logic                 fail;
  gap_t                 g;
  gap_t                 d;
  logic [SLOT_BITS-1:0] repl_slot;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  assign n_ok  = (pick_q != '0) && (32'(pick_q) <= 32'(MAX_PICK));
  assign n_cnt = CNT_W'(pick_q);
  assign g     = gap_of(target_q, item_time_i);
  assign d     = gap_of(target_q, ram_rdata[TIME_W-1:0]);
  assign fill  = n_ok && (seen_q < SEEN_W'(pick_q));
  assign repl  = n_ok && !fill && gap_pos(g) && (!gap_pos(largest_q) || (g < largest_q));
  assign fail  = !n_ok || (seen_q < SEEN_W'(pick_q)) || (empty_q != '0);
  assign repl_slot = (32'(lslot_q) < 32'(MAX_PICK)) ? lslot_q : '0;

  assign ram_wdata = {item_index_i, item_time_i};

  kcpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PICK),
    .ADDR_W(SLOT_BITS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    largest_d = largest_q;
    lslot_d   = lslot_q;
    empty_d   = empty_q;
    seen_d    = seen_q;
    last_d    = last_q;
    iss_d     = iss_q;
    rvld_d    = 1'b0;
    rslot_d   = rslot_q;
    strobe_d  = 1'b0;
    found_d   = found_q;
    oslot_d   = oslot_q;
    olast_d   = olast_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_raddr = iss_q[SLOT_BITS-1:0];

    unique case (state_q)
      S_IDLE: begin
        iss_d = '0;
        if (accept) begin
          last_d = is_last_i;
          if (fill) begin
            ram_we    = 1'b1;
            ram_waddr = seen_q[SLOT_BITS-1:0];
            if (!gap_pos(g) && (empty_q != EMPTY_MAX)) begin
              empty_d = empty_q + 1'b1;
            end
            if ((g > largest_q) || !gap_pos(g)) begin
              largest_d = g;
              lslot_d   = seen_q[SLOT_BITS-1:0];
            end
          end
          if (repl) begin
            ram_we    = 1'b1;
            ram_waddr = repl_slot;
            if (empty_q != '0) begin
              empty_d = empty_q - 1'b1;
            end
            largest_d = g;
          end
          if (seen_q != SEEN_MAX) begin
            seen_d = seen_q + 1'b1;
          end
          if (repl) begin
            state_d = S_SCAN;
          end else if (is_last_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (rvld_q && gap_pos(largest_q)) begin
          if ((d > largest_q) || !gap_pos(d)) begin
            largest_d = d;
            lslot_d   = rslot_q;
          end
        end
        if (iss_q < n_cnt) begin
          rvld_d  = 1'b1;
          rslot_d = iss_q[SLOT_BITS-1:0];
          iss_d   = iss_q + 1'b1;
        end
        if (!gap_pos(largest_q) || (rvld_q && (iss_q == n_cnt))) begin
          rvld_d  = 1'b0;
          iss_d   = '0;
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        strobe_d = 1'b1;
        if (fail) begin
          found_d   = 1'b0;
          oslot_d   = '0;
          olast_d   = 1'b1;
          largest_d = '0;
          lslot_d   = '0;
          empty_d   = '0;
          seen_d    = '0;
          iss_d     = '0;
          state_d   = S_IDLE;
        end else begin
          found_d = 1'b1;
          oslot_d = iss_q[SLOT_BITS-1:0];
          olast_d = (iss_q == (n_cnt - 1'b1));
          iss_d   = iss_q + 1'b1;
          if (iss_q == (n_cnt - 1'b1)) begin
            largest_d = '0;
            lslot_d   = '0;
            empty_d   = '0;
            seen_d    = '0;
            iss_d     = '0;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      pick_q   <= PICK_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET_TIME: target_q <= cfg_data_i[TIME_W-1:0];
        REG_PICK_COUNT:  pick_q   <= cfg_data_i[PICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      largest_q <= '0;
      lslot_q   <= '0;
      empty_q   <= '0;
      seen_q    <= '0;
      last_q    <= 1'b0;
      iss_q     <= '0;
      rvld_q    <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      largest_q <= largest_d;
      lslot_q   <= lslot_d;
      empty_q   <= empty_d;
      seen_q    <= seen_d;
      last_q    <= last_d;
      iss_q     <= iss_d;
      rvld_q    <= rvld_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q <= rslot_d;
    found_q <= found_d;
    oslot_q <= oslot_d;
    olast_q <= olast_d;
  end

  assign result_strobe_o = strobe_q;
  assign found_o         = found_q;
  assign slot_number_o   = oslot_q;
  assign last_result_o   = olast_q;
  assign chosen_index_o  = found_q ? ram_rdata[ENTRY_W-1:TIME_W] : '0;
  assign chosen_time_o   = found_q ? ram_rdata[TIME_W-1:0] : '0;

endmodule

### hdl/kcpt_checker.sv
// port-level assertions for the closest prior time selector, bound to the top level
module kcpt_checker
  import kcpt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  busy_o,
  input logic                  result_strobe_o,
  input logic                  found_o,
  input logic [SLOT_BITS-1:0]  slot_number_o,
  input logic [INDEX_BITS-1:0] chosen_index_o,
  input logic [TIME_W-1:0]     chosen_time_o,
  input logic                  last_result_o
);

  // results only come out of a readout
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o))
    else $error("result without preceding readout");

  // a failure is the single and final result, all zero
  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !found_o) |-> (last_result_o && (slot_number_o == '0) &&
      (chosen_index_o == '0) && (chosen_time_o == '0)))
    else $error("malformed failure result");

  // the readout ends with the final result
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_result_o) |-> !busy_o)
    else $error("still busy after final result");

  // slots come out back to back in order
  a_slot_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_result_o) |=> (result_strobe_o && found_o &&
      (slot_number_o == SLOT_BITS'($past(slot_number_o) + 1'b1))))
    else $error("slot readout out of order");

  // the block stays busy through a readout
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_result_o) |-> busy_o)
    else $error("idle in the middle of a readout");

endmodule

bind k_closest_prior_time_select kcpt_checker u_kcpt_checker (.*);
